@@ hdl/tcw_pkg.sv @@
`default_nettype none
package tcw_pkg;

  // field widths of the request and response items
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int CELL_W   = 16;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int ATTR_W   = 8;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_ATTR = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;

  // prompt is two cells wide
  localparam int PROMPT_LEN = 2;

  // reset values of the attribute registers
  localparam logic [ATTR_W-1:0] TEXT_ATTR_RST   = 8'd7;
  localparam logic [ATTR_W-1:0] PROMPT_ATTR_RST = 8'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic              scrolled;
  } rsp_t;

  typedef struct packed {
    logic [ATTR_W-1:0] text_attribute;
    logic [ATTR_W-1:0] prompt_attribute;
  } attr_t;

endpackage
`default_nettype wire

@@ hdl/tcw_stream_if.sv @@
`default_nettype none
interface tcw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/tcw_screen_mem.sv @@
`default_nettype none
module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
  input  wire logic [AW-1:0]              raddr,
  output logic [tcw_pkg::CELL_W-1:0]      rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/tcw_engine.sv @@
`default_nettype none
module tcw_engine #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STEP      = 4,
  parameter int AW            = 11
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tcw_pkg::attr_t             attr,
  tcw_stream_if.sink                      req,
  tcw_stream_if.source                    rsp,
  output logic                            mem_we,
  output logic [AW-1:0]                   mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0]      mem_wdata,
  output logic [AW-1:0]                   mem_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] mem_rdata
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int RW = (SCREEN_HEIGHT > 2) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int CW = $clog2(SCREEN_WIDTH + TAB_STEP);

  localparam logic [AW-1:0] WIDTH_A    = AW'(SCREEN_WIDTH);
  localparam logic [AW-1:0] LAST_A     = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] LAST_ROW_A = AW'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
  localparam logic [RW-1:0] LAST_ROW_R = RW'(SCREEN_HEIGHT - 1);
  localparam logic [CW-1:0] WIDTH_C    = CW'(SCREEN_WIDTH);
  localparam logic [CW-1:0] TAB_C      = CW'(TAB_STEP);
  localparam logic [CW-1:0] PROMPT_C   = CW'(PROMPT_LEN);
  localparam logic [1:0]    LEAD_DONE  = 2'(PROMPT_LEN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_COPY,
    S_COPY_LAST,
    S_READ,
    S_FINISH
  } state_t;

  state_t            state;
  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     fill_end;
  logic [AW-1:0]     wb_addr;
  logic              pend;
  logic [1:0]        lead;
  logic              in_range;
  logic              scrolled;
  logic [CELL_W-1:0] value;

  logic              accept;
  logic [AW-1:0]     row_base;
  logic [AW-1:0]     cursor_addr;
  logic [AW-1:0]     next_row_base;
  logic [CELL_W-1:0] blank_cell;
  logic              is_newline;
  logic              is_tab;
  logic [CW-1:0]     col_plus1;
  logic [CW-1:0]     col_plus_tab;
  logic              put_step;
  logic              put_prompt;
  logic [CW-1:0]     put_col;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // cursor address arithmetic
  assign row_base      = AW'(row) * WIDTH_A;
  assign cursor_addr   = row_base + AW'(col);
  assign next_row_base = row_base + WIDTH_A;
  assign blank_cell    = {attr.text_attribute, CH_SPACE};

  // cursor movement for put character
  always_comb begin
    is_newline   = (req.payload.char_code == CH_LF) || (req.payload.char_code == CH_CR);
    is_tab       = (req.payload.char_code == CH_TAB);
    col_plus1    = col + CW'(1);
    col_plus_tab = col + TAB_C;
    put_step     = 1'b0;
    put_prompt   = 1'b0;
    put_col      = col_plus1;
    if (is_newline) begin
      put_step   = 1'b1;
      put_prompt = 1'b1;
      put_col    = PROMPT_C;
    end else if (is_tab) begin
      if (col_plus_tab >= WIDTH_C) begin
        put_step = 1'b1;
        put_col  = col_plus_tab - WIDTH_C;
      end else begin
        put_col = col_plus_tab;
      end
    end else if (col_plus1 >= WIDTH_C) begin
      put_step   = 1'b1;
      put_prompt = 1'b1;
      put_col    = PROMPT_C;
    end
  end

  // screen memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = blank_cell;
    mem_raddr = addr;
    unique case (state)
      S_IDLE: begin
        mem_raddr = AW'(req.payload.cell_index);
        mem_waddr = cursor_addr;
        mem_wdata = {attr.text_attribute, req.payload.char_code};
        mem_we    = accept && (req.payload.operation == OP_PUT) && !is_newline && !is_tab;
      end
      S_FILL: begin
        mem_we = 1'b1;
        if (lead == 2'd0) begin
          mem_wdata = {attr.prompt_attribute, CH_DOLLAR};
        end else if (lead == 2'd1) begin
          mem_wdata = {attr.prompt_attribute, CH_SPACE};
        end
      end
      S_COPY: begin
        mem_we    = pend;
        mem_waddr = wb_addr;
        mem_wdata = mem_rdata;
      end
      S_COPY_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = wb_addr;
        mem_wdata = mem_rdata;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer, cursor and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      col       <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // a response taken while the next one is being loaded is handled below
      if (rsp.valid && rsp.ready && (state != S_FINISH)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            scrolled <= 1'b0;
            value    <= '0;
            pend     <= 1'b0;
            case (req.payload.operation)
              OP_CLEAR: begin
                col      <= PROMPT_C;
                addr     <= (row == '0) ? '0 : WIDTH_A;
                lead     <= (row == '0) ? 2'd0 : LEAD_DONE;
                fill_end <= LAST_A;
                state    <= S_FILL;
              end
              OP_PUT: begin
                if (put_step && (row == LAST_ROW_R)) begin
                  // bottom reached: move rows up, then prompt on the last row
                  col      <= PROMPT_C;
                  addr     <= WIDTH_A;
                  scrolled <= 1'b1;
                  state    <= S_COPY;
                end else if (put_step && put_prompt) begin
                  row      <= row + RW'(1);
                  col      <= PROMPT_C;
                  addr     <= next_row_base;
                  fill_end <= next_row_base + WIDTH_A - AW'(1);
                  lead     <= 2'd0;
                  state    <= S_FILL;
                end else if (put_step) begin
                  row   <= row + RW'(1);
                  col   <= put_col;
                  state <= S_FINISH;
                end else begin
                  col   <= put_col;
                  state <= S_FINISH;
                end
              end
              OP_READ: begin
                in_range <= (int'(req.payload.cell_index) < CELL_COUNT);
                state    <= S_READ;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_FILL: begin
          if (lead != LEAD_DONE) begin
            lead <= lead + 2'd1;
          end
          addr <= addr + AW'(1);
          if (addr == fill_end) begin
            state <= S_FINISH;
          end
        end
        S_COPY: begin
          // read ahead one cell, write the previous one a row higher
          addr    <= addr + AW'(1);
          pend    <= 1'b1;
          wb_addr <= addr - WIDTH_A;
          if (addr == LAST_A) begin
            state <= S_COPY_LAST;
          end
        end
        S_COPY_LAST: begin
          pend     <= 1'b0;
          addr     <= LAST_ROW_A;
          fill_end <= LAST_A;
          lead     <= 2'd0;
          state    <= S_FILL;
        end
        S_READ: begin
          value <= in_range ? mem_rdata : '0;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid                 <= 1'b1;
            rsp.payload.cell_value    <= value;
            rsp.payload.cursor_row    <= ROW_W'(row);
            rsp.payload.cursor_column <= COL_W'(col);
            rsp.payload.scrolled      <= scrolled;
            state                     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // cursor stays on the screen
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= LAST_ROW_R)
    else $error("cursor row beyond last row");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col < WIDTH_C)
    else $error("cursor column beyond screen width");

  // during a scroll the read address runs one row and one cell ahead of the write address
  a_copy_pace: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) && pend |-> mem_raddr == mem_waddr + WIDTH_A + AW'(1))
    else $error("scroll copy out of step");

  // a scroll always leaves the cursor after the prompt
  a_scroll_col: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.scrolled |->
      (rsp.payload.cursor_column == COL_W'(PROMPT_LEN)) &&
      (rsp.payload.cursor_row == ROW_W'(SCREEN_HEIGHT - 1)))
    else $error("scroll left cursor off the prompt");

endmodule
`default_nettype wire

@@ hdl/text_console_writer_core.sv @@
`default_nettype none
// Text console writer: keeps a SCREEN_HEIGHT by SCREEN_WIDTH screen of 16-bit cells
// (attribute high byte, character low byte) in one single-port-write memory and a
// cursor, and answers each request (clear, put character, read cell) with one response
// carrying the cell read, the cursor after the request and a scroll flag. The memory
// takes one write per cycle: a plain character is written at the cursor, a tab only
// moves the cursor, a read uses the registered read port, a new row is filled with its
// prompt and blanks, a clear writes blank cells, and a scroll moves every row up one
// cell at a time and then writes the prompt row. One request is worked on at a time;
// a finished response waits in an output register while the next request is taken.
// Screen contents are undefined after reset, so issue a clear before the first read.
// The user writes attribute registers only while idle; the block does not enforce it.
module text_console_writer_core #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STEP      = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tcw_stream_if.sink                         req,
  tcw_stream_if.source                       rsp,
  input  wire logic                          cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_data
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW         = $clog2(CELL_COUNT);

  attr_t             attr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // attribute registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attr.text_attribute   <= TEXT_ATTR_RST;
      attr.prompt_attribute <= PROMPT_ATTR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEXT_ATTR:   attr.text_attribute   <= cfg_data;
        CFG_PROMPT_ATTR: attr.prompt_attribute <= cfg_data;
        default:         attr                  <= attr;
      endcase
    end
  end

  // request sequencer
  tcw_engine #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TAB_STEP      (TAB_STEP),
    .AW            (AW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // screen cell memory
  tcw_screen_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_screen_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
